// ===== rtl/cht_pkg.sv =====
// Shared types, sizes and helper functions of the cuckoo hash table.
// It has no dependencies. The controller, the bucket store and the top level use it.
package cht_pkg;

   localparam int BUCKET_BITS      = 12;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int KEY_W            = 32;
   localparam int FP_W             = KEY_W - BUCKET_BITS;
   localparam int BUCKET_COUNT     = 1 << BUCKET_BITS;
   localparam int NUM_SLOTS        = BUCKET_COUNT * SLOTS_PER_BUCKET;
   localparam int COUNT_W          = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_IDX_W       = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int KICK_W           = 10;
   localparam int HEIGHT_W         = 32;
   localparam int AMOUNT_W         = 51;
   localparam int LFSR_W           = 16;

   localparam logic [63:0]       FP_MULT     = 64'hCC9E2D51;
   localparam logic [KICK_W-1:0] KICKS_RESET = KICK_W'(500);
   localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
   // floor(2^16 / slots) for the victim slot reduction
   localparam logic [16:0]       SLOT_RECIP  = 17'((64'd1 << 16) / SLOTS_PER_BUCKET);

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef logic [BUCKET_BITS-1:0] bucket_type;
   typedef logic [SLOT_IDX_W-1:0]  slot_idx_type;

   typedef struct packed {
      logic                valid;
      logic                sel;
      logic [FP_W-1:0]     fp;
      logic                cb;
      logic [HEIGHT_W-1:0] height;
      logic [AMOUNT_W-1:0] amount;
   } slot_type;

   typedef slot_type [SLOTS_PER_BUCKET-1:0] row_type;

   typedef struct packed {
      logic         hit;
      slot_idx_type idx;
   } find_type;

   // memory read and write port towards the bucket store
   typedef struct packed {
      logic       wr_en;
      bucket_type wr_addr;
      row_type    wr_data;
      logic       rd_en;
      bucket_type rd_addr;
   } mem_req_type;

   function automatic bucket_type fp_hash(logic [FP_W-1:0] fp);
      logic [63:0] prod;
      prod = 64'(fp) * FP_MULT;
      return prod[BUCKET_BITS-1:0];
   endfunction

   function automatic find_type find_match(row_type row, logic [FP_W-1:0] fp, logic sel);
      find_type f;
      f = '0;
      for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
         if (row[s].valid && row[s].fp == fp && row[s].sel == sel) begin
            f.hit = 1'b1;
            f.idx = SLOT_IDX_W'(s);
         end
      end
      return f;
   endfunction

   function automatic find_type find_free(row_type row);
      find_type f;
      f = '0;
      for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
         if (!row[s].valid) begin
            f.hit = 1'b1;
            f.idx = SLOT_IDX_W'(s);
         end
      end
      return f;
   endfunction

   function automatic logic [LFSR_W-1:0] lfsr_next(logic [LFSR_W-1:0] l);
      return {l[0] ^ l[2] ^ l[3] ^ l[5], l[LFSR_W-1:1]};
   endfunction

   // x mod slots by reciprocal multiply; the quotient runs short by at most two
   function automatic slot_idx_type victim_slot(logic [LFSR_W-1:0] x);
      logic [32:0] prod;
      logic [16:0] q;
      logic [16:0] r;
      prod = 33'(x) * 33'(SLOT_RECIP);
      q    = prod[32:16];
      r    = 17'(x) - 17'(q * 17'(SLOTS_PER_BUCKET));
      if (r >= 17'(SLOTS_PER_BUCKET)) r = r - 17'(SLOTS_PER_BUCKET);
      if (r >= 17'(SLOTS_PER_BUCKET)) r = r - 17'(SLOTS_PER_BUCKET);
      return SLOT_IDX_W'(r);
   endfunction

endpackage

// ===== rtl/cuckoo_hash_table_top.sv =====
// Top level of the four-way cuckoo hash table: max_kicks register and wiring.
// Depends on cht_pkg, cht_store and cht_ctrl.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  cmd, key_hash, in_coinbase, in_height, in_amount
//   rsp_     out        rsp_valid / rsp_stall  status, out_coinbase, out_height, out_amount,
//                                              entry_count
//   csr_     in         csr_wr_en              csr_wr_data (max_kicks)
//
// Lookup, remove and an insert that finds a free slot go from the accept through two reads
// of the bucket store, a decide and a hand-off state that loads the result register; a new
// word is taken only after the hand-off, when the controller is back in idle.
// Each relocation step of an insert passes through an LFSR step, a swap write, a reread and a check.
// After reset a clearing pass writes one bucket a cycle through all 4096 buckets, with req_stall high.
// A stalled result holds in the output register; the next word is taken meanwhile and
// waits in the hand-off state until the register frees.
module cuckoo_hash_table_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [cht_pkg::KEY_W-1:0]        req_key_hash,
   input  logic                             req_in_coinbase,
   input  logic [cht_pkg::HEIGHT_W-1:0]     req_in_height,
   input  logic [cht_pkg::AMOUNT_W-1:0]     req_in_amount,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_out_coinbase,
   output logic [cht_pkg::HEIGHT_W-1:0]     rsp_out_height,
   output logic [cht_pkg::AMOUNT_W-1:0]     rsp_out_amount,
   output logic [cht_pkg::COUNT_W-1:0]      rsp_entry_count,
   input  logic                             csr_wr_en,
   input  logic [cht_pkg::KICK_W-1:0]       csr_wr_data
);

   logic [cht_pkg::KICK_W-1:0] max_kicks_ff;
   cht_pkg::mem_req_type       mem_req;
   cht_pkg::row_type           mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_kicks_ff <= cht_pkg::KICKS_RESET;
      end else if (csr_wr_en) begin
         max_kicks_ff <= csr_wr_data;
      end
   end

   cht_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .max_kicks        (max_kicks_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key_hash     (req_key_hash),
      .req_in_coinbase  (req_in_coinbase),
      .req_in_height    (req_in_height),
      .req_in_amount    (req_in_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_coinbase (rsp_out_coinbase),
      .rsp_out_height   (rsp_out_height),
      .rsp_out_amount   (rsp_out_amount),
      .rsp_entry_count  (rsp_entry_count),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

   cht_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== rtl/cht_store.sv =====
// Bucket store: one row of all slots of a bucket per address.
// Depends on cht_pkg. One write and one registered read per cycle.
module cht_store (
   input  logic                 clock,
   input  cht_pkg::mem_req_type mem_req,
   output cht_pkg::row_type     rd_data
);

   cht_pkg::row_type mem [cht_pkg::BUCKET_COUNT];
   cht_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cht_ctrl.sv =====
// Sequencer of the cuckoo table: clearing pass, bucket reads, insert with kicks.
// Depends on cht_pkg; drives the cht_store ports and the result register.
module cht_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [cht_pkg::KICK_W-1:0]       max_kicks,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [cht_pkg::KEY_W-1:0]        req_key_hash,
   input  logic                             req_in_coinbase,
   input  logic [cht_pkg::HEIGHT_W-1:0]     req_in_height,
   input  logic [cht_pkg::AMOUNT_W-1:0]     req_in_amount,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_out_coinbase,
   output logic [cht_pkg::HEIGHT_W-1:0]     rsp_out_height,
   output logic [cht_pkg::AMOUNT_W-1:0]     rsp_out_amount,
   output logic [cht_pkg::COUNT_W-1:0]      rsp_entry_count,
   output cht_pkg::mem_req_type             mem_req,
   input  cht_pkg::row_type                 mem_rd_data
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WAIT_P, S_WAIT_A, S_DECIDE,
      S_KICK, S_KSWAP, S_KREAD, S_KCHECK, S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   cht_pkg::bucket_type            clr_ff, clr_in;
   logic [1:0]                     cmd_ff, cmd_in;
   logic [cht_pkg::FP_W-1:0]       fp_ff, fp_in;
   cht_pkg::bucket_type            p_ff, p_in;
   cht_pkg::bucket_type            a_ff, a_in;
   cht_pkg::bucket_type            target_ff, target_in;
   cht_pkg::slot_type              item_ff, item_in;
   cht_pkg::row_type               row_p_ff, row_p_in;
   cht_pkg::row_type               row_t_ff, row_t_in;
   cht_pkg::slot_idx_type          vic_ff, vic_in;
   logic [cht_pkg::LFSR_W-1:0]     lfsr_ff, lfsr_in;
   logic [cht_pkg::KICK_W-1:0]     kick_ff, kick_in;
   logic [cht_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [1:0]                     res_status_ff, res_status_in;
   cht_pkg::slot_type              res_slot_ff, res_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic                           rsp_cb_ff, rsp_cb_in;
   logic [cht_pkg::HEIGHT_W-1:0]   rsp_height_ff, rsp_height_in;
   logic [cht_pkg::AMOUNT_W-1:0]   rsp_amount_ff, rsp_amount_in;
   logic [cht_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   cht_pkg::find_type              pm, am, pf, af, kf;
   cht_pkg::row_type               row_w;
   cht_pkg::slot_type              victim;
   cht_pkg::bucket_type            key_p;
   logic [cht_pkg::FP_W-1:0]       key_fp;
   logic                           out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign key_p     = req_key_hash[cht_pkg::BUCKET_BITS-1:0];
   assign key_fp    = req_key_hash[cht_pkg::KEY_W-1:cht_pkg::BUCKET_BITS];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      fp_in         = fp_ff;
      p_in          = p_ff;
      a_in          = a_ff;
      target_in     = target_ff;
      item_in       = item_ff;
      row_p_in      = row_p_ff;
      row_t_in      = row_t_ff;
      vic_in        = vic_ff;
      lfsr_in       = lfsr_ff;
      kick_in       = kick_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_cb_in     = rsp_cb_ff;
      rsp_height_in = rsp_height_ff;
      rsp_amount_in = rsp_amount_ff;
      rsp_count_in  = rsp_count_ff;
      mem_req         = '0;
      mem_req.wr_addr = target_ff;
      mem_req.rd_addr = p_ff;
      row_w  = row_t_ff;
      victim = row_t_ff[vic_ff];
      pm = cht_pkg::find_match(row_p_ff, fp_ff, 1'b0);
      am = cht_pkg::find_match(row_t_ff, fp_ff, 1'b1);
      pf = cht_pkg::find_free(row_p_ff);
      af = cht_pkg::find_free(row_t_ff);
      kf = cht_pkg::find_free(mem_rd_data);

      case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == cht_pkg::bucket_type'(cht_pkg::BUCKET_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in          = req_cmd;
               fp_in           = key_fp;
               p_in            = key_p;
               a_in            = key_p ^ cht_pkg::fp_hash(key_fp);
               item_in         = {1'b1, 1'b0, key_fp, req_in_coinbase,
                                  req_in_height, req_in_amount};
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = key_p;
               state_in        = S_WAIT_P;
            end
         end
         S_WAIT_P: begin
            row_p_in        = mem_rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = a_ff;
            state_in        = S_WAIT_A;
         end
         S_WAIT_A: begin
            row_t_in  = mem_rd_data;
            target_in = a_ff;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            res_status_in = cht_pkg::ST_NOT_FOUND;
            res_slot_in   = '0;
            state_in      = S_DONE;
            case (cmd_ff)
               cht_pkg::CMD_LOOKUP: begin
                  if (pm.hit) begin
                     res_status_in = cht_pkg::ST_OK;
                     res_slot_in   = row_p_ff[pm.idx];
                  end else if (am.hit) begin
                     res_status_in = cht_pkg::ST_OK;
                     res_slot_in   = row_t_ff[am.idx];
                  end
               end
               cht_pkg::CMD_REMOVE: begin
                  if (pm.hit || am.hit) begin
                     res_status_in = cht_pkg::ST_OK;
                     mem_req.wr_en = 1'b1;
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                     if (pm.hit) begin
                        row_w           = row_p_ff;
                        row_w[pm.idx]   = '0;
                        mem_req.wr_addr = p_ff;
                     end else begin
                        row_w[am.idx]   = '0;
                        mem_req.wr_addr = a_ff;
                     end
                     mem_req.wr_data = row_w;
                  end
               end
               cht_pkg::CMD_INSERT: begin
                  if (pm.hit || am.hit) begin
                     res_status_in = cht_pkg::ST_DUPLICATE;
                  end else if (pf.hit || af.hit) begin
                     res_status_in = cht_pkg::ST_OK;
                     mem_req.wr_en = 1'b1;
                     count_in      = count_ff + 1'b1;
                     if (pf.hit) begin
                        row_w           = row_p_ff;
                        row_w[pf.idx]   = item_ff;
                        mem_req.wr_addr = p_ff;
                     end else begin
                        row_w[af.idx]     = item_ff;
                        row_w[af.idx].sel = 1'b1;
                        mem_req.wr_addr   = a_ff;
                     end
                     mem_req.wr_data = row_w;
                  end else if (max_kicks == '0) begin
                     res_status_in = cht_pkg::ST_FULL;
                  end else begin
                     item_in.sel = 1'b1;
                     kick_in     = '0;
                     state_in    = S_KICK;
                  end
               end
               default: begin
                  res_status_in = cht_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         S_KICK: begin
            lfsr_in  = cht_pkg::lfsr_next(lfsr_ff);
            vic_in   = cht_pkg::victim_slot(cht_pkg::lfsr_next(lfsr_ff));
            state_in = S_KSWAP;
         end
         S_KSWAP: begin
            // homeless word takes the victim's slot, victim heads for its other bucket
            row_w[vic_ff]   = item_ff;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = row_w;
            item_in         = victim;
            item_in.sel     = ~victim.sel;
            target_in       = target_ff ^ cht_pkg::fp_hash(victim.fp);
            kick_in         = kick_ff + 1'b1;
            state_in        = S_KREAD;
         end
         S_KREAD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = target_ff;
            state_in        = S_KCHECK;
         end
         S_KCHECK: begin
            row_t_in    = mem_rd_data;
            res_slot_in = '0;
            if (kf.hit) begin
               row_w           = mem_rd_data;
               row_w[kf.idx]   = item_ff;
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = row_w;
               count_in        = count_ff + 1'b1;
               res_status_in   = cht_pkg::ST_OK;
               state_in        = S_DONE;
            end else if (kick_ff == max_kicks) begin
               res_status_in = cht_pkg::ST_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_KICK;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cb_in     = res_slot_ff.cb;
               rsp_height_in = res_slot_ff.height;
               rsp_amount_in = res_slot_ff.amount;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lfsr_ff      <= cht_pkg::LFSR_SEED;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lfsr_ff      <= lfsr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      fp_ff         <= fp_in;
      p_ff          <= p_in;
      a_ff          <= a_in;
      target_ff     <= target_in;
      item_ff       <= item_in;
      row_p_ff      <= row_p_in;
      row_t_ff      <= row_t_in;
      vic_ff        <= vic_in;
      kick_ff       <= kick_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cb_ff     <= rsp_cb_in;
      rsp_height_ff <= rsp_height_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_coinbase = rsp_cb_ff;
   assign rsp_out_height   = rsp_height_ff;
   assign rsp_out_amount   = rsp_amount_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

// ===== rtl/cht_checker.sv =====
// Port-level checks of the cuckoo hash table, bound to the top level.
// Depends on cht_pkg and cuckoo_hash_table_top.
module cht_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic                         rsp_out_coinbase,
   input logic [cht_pkg::HEIGHT_W-1:0] rsp_out_height,
   input logic [cht_pkg::AMOUNT_W-1:0] rsp_out_amount,
   input logic [cht_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_amount)
         && $stable(rsp_entry_count))
      else $error("stalled result changed");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cht_pkg::ST_OK |->
         rsp_out_amount == '0 && rsp_out_height == '0 && !rsp_out_coinbase)
      else $error("payload not zero on a miss");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= cht_pkg::COUNT_W'(cht_pkg::NUM_SLOTS))
      else $error("entry count beyond capacity");

   // one word in flight: the input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

endmodule

bind cuckoo_hash_table_top cht_checker u_cht_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_coinbase (rsp_out_coinbase),
   .rsp_out_height   (rsp_out_height),
   .rsp_out_amount   (rsp_out_amount),
   .rsp_entry_count  (rsp_entry_count)
);

// ===== sim/cuckoo_hash_table_top_test.sv =====
// Self-checking test of cuckoo_hash_table_top: directed and random lookup, insert and remove
// words checked against a behavioural table model kept in the test. Depends on cht_pkg and cuckoo_hash_table_top.
module cuckoo_hash_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                   status;
      logic                         cb;
      logic [cht_pkg::HEIGHT_W-1:0] height;
      logic [cht_pkg::AMOUNT_W-1:0] amount;
      logic [cht_pkg::COUNT_W-1:0]  count;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [cht_pkg::KEY_W-1:0] req_key_hash = '0;
   logic req_in_coinbase = 1'b0;
   logic [cht_pkg::HEIGHT_W-1:0] req_in_height = '0;
   logic [cht_pkg::AMOUNT_W-1:0] req_in_amount = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_out_coinbase;
   logic [cht_pkg::HEIGHT_W-1:0] rsp_out_height;
   logic [cht_pkg::AMOUNT_W-1:0] rsp_out_amount;
   logic [cht_pkg::COUNT_W-1:0] rsp_entry_count;
   logic csr_wr_en = 1'b0;
   logic [cht_pkg::KICK_W-1:0] csr_wr_data = '0;

   cuckoo_hash_table_top u_top (.*);

   // table model
   cht_pkg::slot_type            model_slots[cht_pkg::NUM_SLOTS];
   logic [cht_pkg::LFSR_W-1:0]   model_lfsr;
   int                           model_count;
   int                           model_kicks;
   answer_type                   pending_answers[$];
   int                           failures = 0;
   int                           send_idle_pct = 0;
   int                           stall_pct = 0;
   int                           hold_req = 0;
   int                           hold_ack = 0;
   int                           hold_left = 0;
   int                           idle_cycles = 0;
   logic [cht_pkg::KEY_W-1:0]    used_keys[$];

   initial forever #1 clock = ~clock;

   function automatic cht_pkg::bucket_type alt_of(cht_pkg::bucket_type b,
                                                  logic [cht_pkg::FP_W-1:0] fp);
      logic [63:0] prod;
      prod = 64'(fp) * cht_pkg::FP_MULT;
      return b ^ prod[cht_pkg::BUCKET_BITS-1:0];
   endfunction

   function automatic int locate(cht_pkg::bucket_type b, logic [cht_pkg::FP_W-1:0] fp,
                                 logic sel);
      int i;
      for (int s = 0; s < cht_pkg::SLOTS_PER_BUCKET; s++) begin
         i = b * cht_pkg::SLOTS_PER_BUCKET + s;
         if (model_slots[i].valid && model_slots[i].fp == fp && model_slots[i].sel == sel)
            return i;
      end
      return -1;
   endfunction

   function automatic int free_in(cht_pkg::bucket_type b);
      for (int s = 0; s < cht_pkg::SLOTS_PER_BUCKET; s++)
         if (!model_slots[b*cht_pkg::SLOTS_PER_BUCKET+s].valid)
            return b*cht_pkg::SLOTS_PER_BUCKET + s;
      return -1;
   endfunction

   function automatic logic [1:0] table_insert(cht_pkg::bucket_type p, cht_pkg::slot_type item);
      cht_pkg::bucket_type a, tgt;
      cht_pkg::slot_type homeless, victim;
      int f, v;
      a = alt_of(p, item.fp);
      homeless = item;
      if (locate(p, item.fp, 1'b0) >= 0 || locate(a, item.fp, 1'b1) >= 0)
         return cht_pkg::ST_DUPLICATE;
      f = free_in(p);
      if (f >= 0) begin
         model_slots[f] = homeless;
         model_count++;
         return cht_pkg::ST_OK;
      end
      f = free_in(a);
      if (f >= 0) begin
         homeless.sel = 1'b1;
         model_slots[f] = homeless;
         model_count++;
         return cht_pkg::ST_OK;
      end
      homeless.sel = 1'b1;
      tgt = a;
      for (int k = 0; k < model_kicks; k++) begin
         model_lfsr = {model_lfsr[0] ^ model_lfsr[2] ^ model_lfsr[3] ^ model_lfsr[5],
                       model_lfsr[cht_pkg::LFSR_W-1:1]};
         v = tgt*cht_pkg::SLOTS_PER_BUCKET + (model_lfsr % cht_pkg::SLOTS_PER_BUCKET);
         victim = model_slots[v];
         model_slots[v] = homeless;
         homeless = victim;
         homeless.sel = ~homeless.sel;
         tgt = alt_of(tgt, homeless.fp);
         f = free_in(tgt);
         if (f >= 0) begin
            model_slots[f] = homeless;
            model_count++;
            return cht_pkg::ST_OK;
         end
      end
      return cht_pkg::ST_FULL;
   endfunction

   function automatic answer_type table_step(logic [1:0] cmd, logic [cht_pkg::KEY_W-1:0] key,
                                             logic cb, logic [cht_pkg::HEIGHT_W-1:0] h,
                                             logic [cht_pkg::AMOUNT_W-1:0] amt);
      answer_type r;
      cht_pkg::bucket_type p, a;
      logic [cht_pkg::FP_W-1:0] fp;
      cht_pkg::slot_type item;
      int i;
      r = '{cht_pkg::ST_NOT_FOUND, 1'b0, '0, '0, '0};
      p = key[cht_pkg::BUCKET_BITS-1:0];
      fp = key[cht_pkg::KEY_W-1:cht_pkg::BUCKET_BITS];
      a = alt_of(p, fp);
      if (cmd == cht_pkg::CMD_LOOKUP || cmd == cht_pkg::CMD_REMOVE) begin
         i = locate(p, fp, 1'b0);
         if (i < 0) i = locate(a, fp, 1'b1);
         if (i >= 0) begin
            r.status = cht_pkg::ST_OK;
            if (cmd == cht_pkg::CMD_LOOKUP) begin
               r.cb = model_slots[i].cb;
               r.height = model_slots[i].height;
               r.amount = model_slots[i].amount;
            end else begin
               model_slots[i] = '0;
               if (model_count > 0) model_count--;
            end
         end
      end else if (cmd == cht_pkg::CMD_INSERT) begin
         item = '{1'b1, 1'b0, fp, cb, h, amt};
         r.status = table_insert(p, item);
      end
      r.count = cht_pkg::COUNT_W'(model_count);
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_word(logic [1:0] cmd, logic [cht_pkg::KEY_W-1:0] key, logic cb = 1'b0,
                            logic [cht_pkg::HEIGHT_W-1:0] h = '0,
                            logic [cht_pkg::AMOUNT_W-1:0] amt = '0);
      answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_key_hash <= key;
      req_in_coinbase <= cb;
      req_in_height <= h;
      req_in_amount <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ans = table_step(cmd, key, cb, h, amt);
      pending_answers.insert(pending_answers.size(), ans);
      if (cmd == cht_pkg::CMD_INSERT) used_keys.insert(used_keys.size(), key);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_kicks(int k);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cht_pkg::KICK_W'(k);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_kicks = k;
   endtask

   function automatic logic [cht_pkg::AMOUNT_W-1:0] rand_amount();
      return cht_pkg::AMOUNT_W'({$urandom, $urandom});
   endfunction

   function automatic logic [cht_pkg::KEY_W-1:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(99) < 60)
         return used_keys[$urandom_range(used_keys.size()-1)];
      return $urandom;
   endfunction

   task automatic test_extremes;
      send_word(cht_pkg::CMD_LOOKUP, '0);
      send_word(cht_pkg::CMD_INSERT, '0, 1'b1, '1, '1);
      send_word(cht_pkg::CMD_INSERT, '0, 1'b0, '0, '0);
      send_word(cht_pkg::CMD_LOOKUP, '0);
      send_word(cht_pkg::CMD_INSERT, '1, 1'b0, '1, 51'd2100000000000000);
      send_word(cht_pkg::CMD_LOOKUP, '1);
      send_word(CMD_UNUSED, '1);
      send_word(cht_pkg::CMD_REMOVE, '1);
      send_word(cht_pkg::CMD_REMOVE, '1);
      send_word(cht_pkg::CMD_LOOKUP, '1);
      send_word(cht_pkg::CMD_REMOVE, '0);
   endtask

   // same primary bucket for many fingerprints: fills it and spills into the alternate buckets
   task automatic test_crowded_bucket(int n);
      for (int i = 0; i < n; i++)
         send_word(cht_pkg::CMD_INSERT, {cht_pkg::FP_W'($urandom_range(63)), 12'h123},
                   1'($urandom), $urandom, rand_amount());
      for (int i = 0; i < 20; i++)
         send_word(cht_pkg::CMD_LOOKUP, {cht_pkg::FP_W'($urandom_range(63)), 12'h123});
   endtask

   // fingerprint 0 hashes to zero, so both buckets coincide
   task automatic test_self_alternate;
      for (int i = 0; i < 6; i++)
         send_word(cht_pkg::CMD_INSERT, {cht_pkg::FP_W'(0), 12'(i * 4096 / 6)});
      for (int i = 0; i < 6; i++)
         send_word(cht_pkg::CMD_INSERT, {cht_pkg::FP_W'(0), 12'h7}, 1'b1,
                   cht_pkg::HEIGHT_W'(i), cht_pkg::AMOUNT_W'(i));
      send_word(cht_pkg::CMD_LOOKUP, {cht_pkg::FP_W'(0), 12'h7});
      send_word(cht_pkg::CMD_REMOVE, {cht_pkg::FP_W'(0), 12'h7});
   endtask

   task automatic test_random(int n);
      logic [1:0] c;
      for (int i = 0; i < n; i++) begin
         c = 2'($urandom_range(99) < 45 ? cht_pkg::CMD_INSERT :
               $urandom_range(99) < 50 ? cht_pkg::CMD_LOOKUP :
               $urandom_range(99) < 95 ? cht_pkg::CMD_REMOVE : CMD_UNUSED);
         send_word(c, pick_key(), 1'($urandom), $urandom, rand_amount());
      end
   endtask

   task automatic test_back_pressure;
      hold_req++;
      test_random(40);
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result word, status %0d", rsp_status);
            failures++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); failures++;
            end
            if (rsp_out_coinbase !== e.cb) begin
               $error("out_coinbase exp %0d got %0d", e.cb, rsp_out_coinbase); failures++;
            end
            if (rsp_out_height !== e.height) begin
               $error("out_height exp %0h got %0h", e.height, rsp_out_height); failures++;
            end
            if (rsp_out_amount !== e.amount) begin
               $error("out_amount exp %0h got %0h", e.amount, rsp_out_amount); failures++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count exp %0d got %0d", e.count, rsp_entry_count); failures++;
            end
         end
      end
   end

   // receiver: random stall, or a long counted hold-off when asked
   always @(negedge clock) begin
      if (hold_ack != hold_req) begin
         hold_ack  <= hold_req;
         hold_left <= 299;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("cuckoo_hash_table_top: mismatch");
         $finish;
      end
   end

   initial begin
      foreach (model_slots[i]) model_slots[i] = '0;
      model_lfsr = cht_pkg::LFSR_SEED;
      model_count = 0;
      model_kicks = int'(cht_pkg::KICKS_RESET);
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_self_alternate();
      test_crowded_bucket(30);
      write_kicks(0);
      test_crowded_bucket(10);
      send_idle_pct = 65;
      test_random(110);
      write_kicks(1023);
      send_idle_pct = 0;
      stall_pct = 65;
      test_random(110);
      test_crowded_bucket(15);
      write_kicks(3);
      send_idle_pct = 17;
      stall_pct = 17;
      test_random(110);
      test_crowded_bucket(10);
      send_idle_pct = 0;
      stall_pct = 0;
      test_back_pressure();
      write_kicks(500);
      test_random(60);
      drain();
      if (failures == 0)
         $display("cuckoo_hash_table_top: match");
      else
         $display("cuckoo_hash_table_top: mismatch");
      $finish;
   end
endmodule
